@@ hdl/line_keyword_id_extract_stack_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the id extract stack
// Shared concurrent-check shorthands, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_KEYWORD_ID_EXTRACT_STACK_TOP_DEFINES_SVH
`define LINE_KEYWORD_ID_EXTRACT_STACK_TOP_DEFINES_SVH

// same-cycle implication
`define LKID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LKID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lkid_pkg.sv @@
// ----------------------------------------------------------------------------
// lkid_pkg
// Types and constants shared by the id extract stack modules.
// ----------------------------------------------------------------------------
package lkid_pkg;

	localparam int STACK_DEPTH_DEF = 256;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0]  BOM_LO   = 8'hFF;
	localparam logic [7:0]  BOM_HI   = 8'hFE;
	localparam logic [15:0] UNIT_P   = 16'h0070;
	localparam logic [15:0] UNIT_V   = 16'h0076;
	localparam logic [15:0] UNIT_US  = 16'h005F;
	localparam logic [15:0] UNIT_TAB = 16'h0009;
	localparam logic [15:0] UNIT_LF  = 16'h000A;
	localparam logic [15:0] UNIT_CR  = 16'h000D;
	localparam logic [15:0] UNIT_SP  = 16'h0020;
	localparam logic [15:0] UNIT_D0  = 16'h0030;
	localparam logic [15:0] UNIT_D9  = 16'h0039;
	localparam logic [31:0] EMPTY_ID = 32'hFFFF_FFFF;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] popped_id;
		logic        was_empty;
		logic        push_dropped;
	} out_item_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [31:0] id;
	} stack_op_t;

endpackage

@@ hdl/line_keyword_id_extract_stack_top.sv @@
// ----------------------------------------------------------------------------
// line_keyword_id_extract_stack_top
// Scans text buffers for "pv_<digits>" line keywords and keeps the ids on
// a LIFO that is popped by command.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | transaction
//  --------+-----------+-------------+--------------------------------------
//  in      | sink      | in_item_t   | one text byte, or one pop command
//  out     | source    | out_item_t  | one popped id per pop command
//
//  Flow: one transaction per clock in, one result per clock out, when not
//  stalled; a byte is parsed in the cycle it is taken, the push or pop is
//  queued and runs in the stack unit (RAM read data registered, top in a flop).
//  Stalls: in_stall rises only when the two-entry request queue is full; it
//  fills when pops wait on a stalled output register.
//  Reset: arst_n clears parse state, stack count, overflow flag and the
//  queue at once; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
module line_keyword_id_extract_stack_top import lkid_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	// parser -> queue
	logic      req_valid;
	stack_op_t req_op;
	logic      queue_full;

	// queue -> stack unit
	logic      head_valid;
	stack_op_t head_op;
	logic      head_take;

	// front end: encoding, keyword and digit parse; stalls only on a full queue
	lkid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.queue_full (queue_full),
		.in_stall   (in_stall),
		.op_valid   (req_valid),
		.op         (req_op)
	);

	// decouples parsing from output back-pressure
	lkid_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (req_valid),
		.wr_op    (req_op),
		.full     (queue_full),
		.rd_valid (head_valid),
		.rd_op    (head_op),
		.rd_take  (head_take)
	);

	// back end: pushes always proceed, pops wait for a free output register
	lkid_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (head_valid),
		.op        (head_op),
		.op_take   (head_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ hdl/lkid_front.sv @@
// ----------------------------------------------------------------------------
// lkid_front
// Byte parser: encoding detect, line keyword match, digit run accumulate.
// Emits one push or pop request per transaction at most.
// ----------------------------------------------------------------------------
module lkid_front import lkid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_item_t  in_data,
	input  logic      queue_full,
	output logic      in_stall,
	output logic      op_valid,
	output stack_op_t op
);

	typedef enum logic [1:0] {
		ENC_UNDECIDED,
		ENC_HELD_FF,
		ENC_BYTES,
		ENC_UTF16
	} enc_t;

	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_SAW_P,
		PH_SAW_PV,
		PH_DIGITS,
		PH_SKIP_LINE
	} phase_t;

	enc_t        enc_q, enc_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  hold_q, hold_d;
	logic        parity_q, parity_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] last_q, last_d;
	logic        push_go;
	logic        take;

	assign in_stall = queue_full;
	assign take     = in_valid && !queue_full;

	always_comb begin
		logic        begin_buf;
		enc_t        e_enc;
		phase_t      ph;
		logic        e_parity;
		logic [31:0] e_acc;
		logic [31:0] e_last;
		logic        unit_go;
		logic [15:0] unit;
		phase_t      rest;
		logic        run_end;
		logic [31:0] acc_x10;

		begin_buf = in_data.first_byte || (enc_q == ENC_UNDECIDED);
		e_enc     = begin_buf ? ENC_UNDECIDED : enc_q;
		ph        = begin_buf ? PH_LINE_START : phase_q;
		e_parity  = begin_buf ? 1'b0 : parity_q;
		e_acc     = begin_buf ? '0 : acc_q;
		e_last    = begin_buf ? '0 : last_q;
		unit_go   = 1'b0;
		unit      = {8'h00, in_data.data_byte};
		run_end   = 1'b0;
		push_go   = 1'b0;

		enc_d    = e_enc;
		hold_d   = hold_q;
		parity_d = e_parity;

		case (e_enc)
			ENC_UNDECIDED: begin
				if (in_data.data_byte == BOM_LO) begin
					enc_d = ENC_HELD_FF;
				end else begin
					enc_d   = ENC_BYTES;
					unit_go = 1'b1;
				end
			end
			ENC_HELD_FF: begin
				if (in_data.data_byte == BOM_HI) begin
					enc_d    = ENC_UTF16;
					parity_d = 1'b0;
				end else begin
					// held FF counts as a unit at line start: line is skipped
					enc_d   = ENC_BYTES;
					ph      = PH_SKIP_LINE;
					unit_go = 1'b1;
				end
			end
			ENC_BYTES: begin
				unit_go = 1'b1;
			end
			default: begin
				if (!e_parity) begin
					hold_d   = in_data.data_byte;
					parity_d = 1'b1;
				end else begin
					unit     = {in_data.data_byte, hold_q};
					parity_d = 1'b0;
					unit_go  = 1'b1;
				end
			end
		endcase

		phase_d = ph;
		acc_d   = e_acc;
		last_d  = e_last;
		rest    = (unit == UNIT_LF || unit == UNIT_CR) ? PH_LINE_START : PH_SKIP_LINE;
		acc_x10 = {e_acc[28:0], 3'b000} + {e_acc[30:0], 1'b0};

		if (unit_go) begin
			case (ph)
				PH_LINE_START: begin
					if (unit == UNIT_TAB || unit == UNIT_LF || unit == UNIT_CR ||
					    unit == UNIT_SP) begin
						phase_d = PH_LINE_START;
					end else if (unit == UNIT_P) begin
						phase_d = PH_SAW_P;
					end else begin
						phase_d = PH_SKIP_LINE;
					end
				end
				PH_SAW_P: begin
					phase_d = (unit == UNIT_V) ? PH_SAW_PV : rest;
				end
				PH_SAW_PV: begin
					if (unit == UNIT_US) begin
						phase_d = PH_DIGITS;
						acc_d   = '0;
					end else begin
						phase_d = rest;
					end
				end
				PH_DIGITS: begin
					if (unit >= UNIT_D0 && unit <= UNIT_D9) begin
						acc_d = acc_x10 + {28'd0, unit[3:0]};
					end else begin
						run_end = 1'b1;
						phase_d = rest;
					end
				end
				default: begin
					phase_d = rest;
				end
			endcase
		end

		if (in_data.last_byte) begin
			if (phase_d == PH_DIGITS) begin
				run_end = 1'b1;
			end
			enc_d = ENC_UNDECIDED;
		end

		// end of run: push a nonzero id unless it repeats the last one
		if (run_end) begin
			push_go = (acc_d != '0) && (acc_d != e_last);
			if (push_go) begin
				last_d = acc_d;
			end
		end

		op.kind = in_data.cmd ? OP_POP : OP_PUSH;
		op.id   = acc_d;

		if (run_end) begin
			acc_d = '0;
		end
	end

	assign op_valid = take && (in_data.cmd || push_go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q    <= ENC_UNDECIDED;
			phase_q  <= PH_LINE_START;
			hold_q   <= '0;
			parity_q <= 1'b0;
			acc_q    <= '0;
			last_q   <= '0;
		end else if (take && !in_data.cmd) begin
			enc_q    <= enc_d;
			phase_q  <= phase_d;
			hold_q   <= hold_d;
			parity_q <= parity_d;
			acc_q    <= acc_d;
			last_q   <= last_d;
		end
	end

endmodule

@@ hdl/lkid_fifo.sv @@
// ----------------------------------------------------------------------------
// lkid_fifo
// Short request queue between parser and stack.
// ----------------------------------------------------------------------------
module lkid_fifo import lkid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	input  stack_op_t wr_op,
	output logic      full,
	output logic      rd_valid,
	output stack_op_t rd_op,
	input  logic      rd_take
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	stack_op_t          slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push, pop;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_op    = slot_q[rd_ptr_q];
	assign push     = wr_valid && !full;
	assign pop      = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/lkid_stack.sv @@
// ----------------------------------------------------------------------------
// lkid_stack
// LIFO back end: top entry in a register, the rest in a RAM. The entry just
// below the top is the registered RAM read, or the forwarded old top.
// ----------------------------------------------------------------------------
`include "line_keyword_id_extract_stack_top_defines.svh"

module lkid_stack import lkid_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	input  stack_op_t op,
	output logic      op_take,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [31:0]       mem [STACK_DEPTH];
	logic [CNT_W-1:0]  count_q, count_d;
	logic [31:0]       top_q;
	logic              overflow_q;
	logic [31:0]       rdata_q, fwd_data_q;
	logic              fwd_q;
	logic [31:0]       below;
	logic              out_valid_q;
	out_item_t         out_data_q;
	logic              out_free;
	logic              push_take, pop_take;
	logic              is_full, is_empty;
	logic              we;
	logic [CNT_W-1:0]  waddr_full, raddr_full;
	logic [ADDR_W-1:0] waddr, raddr;

	assign out_free  = !out_valid_q || !out_stall;
	assign op_take   = op_valid && ((op.kind == OP_PUSH) || out_free);
	assign push_take = op_take && (op.kind == OP_PUSH);
	assign pop_take  = op_take && (op.kind == OP_POP);
	assign is_full   = (count_q == CNT_W'(STACK_DEPTH));
	assign is_empty  = (count_q == '0);

	// old top spills into the RAM on a push taken while neither full nor empty
	assign we         = push_take && !is_full && !is_empty;
	assign waddr_full = count_q - 1'b1;
	assign waddr      = waddr_full[ADDR_W-1:0];

	always_comb begin
		count_d = count_q;
		if (push_take && !is_full) begin
			count_d = count_q + 1'b1;
		end else if (pop_take && !is_empty) begin
			count_d = count_q - 1'b1;
		end
	end

	// read the entry that will sit below the new top
	assign raddr_full = count_d - CNT_W'(2);
	assign raddr      = raddr_full[ADDR_W-1:0];
	assign below      = fwd_q ? fwd_data_q : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= top_q;
		end
		rdata_q    <= mem[raddr];
		fwd_data_q <= top_q;
	end

	always_ff @(posedge clk) begin
		if (push_take && !is_full) begin
			top_q <= op.id;
		end else if (pop_take && !is_empty) begin
			top_q <= below;
		end
		if (pop_take) begin
			out_data_q.popped_id    <= is_empty ? EMPTY_ID : top_q;
			out_data_q.was_empty    <= is_empty;
			out_data_q.push_dropped <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			overflow_q  <= 1'b0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			fwd_q   <= we && (waddr == raddr);
			if (push_take && is_full) begin
				overflow_q <= 1'b1;
			end
			if (pop_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`LKID_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
	`LKID_ASSERT_NEXT(a_full_push_drop, push_take && is_full, overflow_q && (count_q == $past(count_q)), "full push not dropped")
	`LKID_ASSERT_NEXT(a_empty_pop, pop_take && is_empty, out_valid_q && out_data_q.was_empty && (out_data_q.popped_id == EMPTY_ID), "empty pop result wrong")
	`LKID_ASSERT_NEXT(a_push_top, push_take && !is_full, top_q == $past(op.id), "pushed id not on top")
	`LKID_ASSERT_NEXT(a_overflow_sticky, overflow_q, overflow_q, "overflow flag cleared")

endmodule

@@ sim/line_keyword_id_extract_stack_top_test.sv @@
// ----------------------------------------------------------------------------
// line_keyword_id_extract_stack_top_test
// Self-checking bench: drives text bytes and pop commands into the block,
// predicts each popped id with a behavioral copy of the keyword parser and
// id stack, and compares every output transaction field by field.
// ----------------------------------------------------------------------------
module line_keyword_id_extract_stack_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lkid_pkg::*;

	localparam logic CMD_TEXT       = 1'b0;
	localparam logic CMD_POP        = 1'b1;
	localparam int   STORE_DEPTH    = STACK_DEPTH_DEF;
	localparam int   WATCHDOG_LIMIT = 4000;  // cycles without any transaction
	localparam int   LONG_HOLD      = 300;   // receiver back-pressure burst
	localparam int   REPORT_MAX     = 10;

	// encoding and line-parse phases of the behavioral model
	typedef enum logic [1:0] {ENC_OPEN, ENC_FF_HELD, ENC_NARROW, ENC_WIDE} enc_mode_t;
	typedef enum logic [2:0] {LN_START, GOT_P, GOT_PV, IN_DIGITS, SKIP_REST} line_phase_t;

	// one queued input transaction; fixed rows carry a hand-written result
	typedef struct packed {
		in_item_t  item;
		logic      fixed;
		out_item_t want;
	} stim_t;

	// opening script row; push_dropped is always expected low here
	typedef struct packed {
		logic        cmd;
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic        fixed;
		logic [31:0] popped_id;
		logic        was_empty;
	} script_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	line_keyword_id_extract_stack_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Behavioral model state
	// ------------------------------------------------------------------
	enc_mode_t   enc;
	line_phase_t line_phase;
	logic [7:0]  low_hold;
	logic        odd_byte;
	logic [31:0] run_value;
	logic        run_has_digit;
	logic [31:0] prev_id;
	logic [31:0] id_store [STORE_DEPTH];
	int          stack_fill;
	logic        lost_push;

	out_item_t expect_q [$];  // popped ids still owed by the block
	stim_t     stim_q [$];    // input transactions not yet offered
	logic [7:0] text_bytes [$];
	logic       wide_text;

	int   tx_idle_pct = 28;
	int   rx_idle_pct = 85;
	logic hold_request = 1'b0;
	int   fault_count = 0;

	// Opening script: empty pop after reset, a byte-mode keyword line,
	// a UTF-16 line closed by last_byte, lone FF buffers, and pops whose
	// ignored fields sit at their extremes.
	script_row_t opening_script [23] = '{
		'{CMD_POP,  8'h00, 1'b0, 1'b0, 1'b1, EMPTY_ID,     1'b1},
		'{CMD_TEXT, 8'h20, 1'b1, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h70, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h76, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h5F, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h39, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h0A, 1'b0, 1'b1, 1'b0, 32'd0,        1'b0},
		'{CMD_POP,  8'hFF, 1'b1, 1'b1, 1'b1, 32'd9,        1'b0},
		'{CMD_TEXT, 8'hFF, 1'b1, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'hFE, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h70, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h76, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h5F, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h35, 1'b0, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h00, 1'b0, 1'b1, 1'b0, 32'd0,        1'b0},
		'{CMD_POP,  8'h00, 1'b0, 1'b0, 1'b1, 32'd5,        1'b0},
		'{CMD_TEXT, 8'hFF, 1'b1, 1'b0, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'h70, 1'b0, 1'b1, 1'b0, 32'd0,        1'b0},
		'{CMD_TEXT, 8'hFF, 1'b1, 1'b1, 1'b0, 32'd0,        1'b0},
		'{CMD_POP,  8'h00, 1'b0, 1'b0, 1'b1, EMPTY_ID,     1'b1}
	};

	// ------------------------------------------------------------------
	// Keyword parser and id stack prediction
	// ------------------------------------------------------------------
	function automatic void start_buffer();
		enc           = ENC_OPEN;
		line_phase    = LN_START;
		low_hold      = '0;
		odd_byte      = 1'b0;
		run_value     = '0;
		run_has_digit = 1'b0;
		prev_id       = '0;
	endfunction

	// a finished digit run pushes its id unless zero or a repeat of the last
	function automatic void close_run();
		if (run_has_digit && run_value != 0 && run_value != prev_id) begin
			prev_id = run_value;
			if (stack_fill < STORE_DEPTH) begin
				id_store[stack_fill] = run_value;
				stack_fill++;
			end else begin
				lost_push = 1'b1;  // dropped, but still counts as last id
			end
		end
		run_has_digit = 1'b0;
		run_value     = '0;
	endfunction

	function automatic line_phase_t after_char(logic [15:0] u);
		return (u == UNIT_LF || u == UNIT_CR) ? LN_START : SKIP_REST;
	endfunction

	function automatic void scan_unit(logic [15:0] u);
		case (line_phase)
			LN_START: begin
				if (u == UNIT_TAB || u == UNIT_LF || u == UNIT_CR || u == UNIT_SP)
					line_phase = LN_START;
				else if (u == UNIT_P)
					line_phase = GOT_P;
				else
					line_phase = SKIP_REST;
			end
			GOT_P: line_phase = (u == UNIT_V) ? GOT_PV : after_char(u);
			GOT_PV: begin
				if (u == UNIT_US) begin
					line_phase    = IN_DIGITS;
					run_value     = '0;
					run_has_digit = 1'b0;
				end else begin
					line_phase = after_char(u);
				end
			end
			IN_DIGITS: begin
				if (u >= UNIT_D0 && u <= UNIT_D9) begin
					run_value     = run_value * 32'd10 + 32'(u - UNIT_D0);
					run_has_digit = 1'b1;
				end else begin
					close_run();
					line_phase = after_char(u);
				end
			end
			default: line_phase = after_char(u);
		endcase
	endfunction

	// called once per accepted input transaction
	function automatic void predict_item(stim_t s);
		out_item_t  res;
		logic [7:0] b;
		b = s.item.data_byte;
		if (s.item.cmd == CMD_POP) begin
			res.popped_id    = EMPTY_ID;
			res.was_empty    = 1'b1;
			res.push_dropped = lost_push;
			if (stack_fill > 0) begin
				stack_fill--;
				res.popped_id = id_store[stack_fill];
				res.was_empty = 1'b0;
			end
			expect_q.insert(expect_q.size(), s.fixed ? s.want : res);
			return;
		end
		if (s.item.first_byte || enc == ENC_OPEN)
			start_buffer();
		case (enc)
			ENC_OPEN: begin
				if (b == BOM_LO) begin
					enc = ENC_FF_HELD;
				end else begin
					enc = ENC_NARROW;
					scan_unit({8'h00, b});
				end
			end
			ENC_FF_HELD: begin
				if (b == BOM_HI) begin
					enc      = ENC_WIDE;
					odd_byte = 1'b0;
				end else begin
					// lone FF: it becomes a byte unit ahead of this one
					enc = ENC_NARROW;
					scan_unit({8'h00, BOM_LO});
					scan_unit({8'h00, b});
				end
			end
			ENC_NARROW: scan_unit({8'h00, b});
			default: begin
				if (!odd_byte) begin
					low_hold = b;
					odd_byte = 1'b1;
				end else begin
					scan_unit({b, low_hold});
					odd_byte = 1'b0;
				end
			end
		endcase
		if (s.item.last_byte) begin
			if (enc == ENC_FF_HELD)
				scan_unit({8'h00, BOM_LO});
			if (line_phase == IN_DIGITS)
				close_run();
			enc = ENC_OPEN;  // an odd trailing byte in wide mode is dropped
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------
	function automatic void queue_text(logic [7:0] b, logic first, logic last);
		stim_t s;
		s                 = '0;
		s.item.cmd        = CMD_TEXT;
		s.item.data_byte  = b;
		s.item.first_byte = first;
		s.item.last_byte  = last;
		stim_q.insert(stim_q.size(), s);
	endfunction

	// pops ignore the other fields, so those are random
	function automatic void queue_pop();
		stim_t s;
		s                 = '0;
		s.item.cmd        = CMD_POP;
		s.item.data_byte  = 8'($urandom_range(0, 255));
		s.item.first_byte = 1'($urandom_range(0, 1));
		s.item.last_byte  = 1'($urandom_range(0, 1));
		stim_q.insert(stim_q.size(), s);
	endfunction

	function automatic void put_unit(logic [15:0] u);
		text_bytes.insert(text_bytes.size(), u[7:0]);
		if (wide_text)
			text_bytes.insert(text_bytes.size(), u[15:8]);
	endfunction

	// wide units now and then carry a nonzero high byte
	function automatic logic [15:0] noise_unit();
		logic [15:0] u;
		u = 16'($urandom_range(0, 255));
		if (wide_text && $urandom_range(0, 15) == 0)
			u[15:8] = 8'($urandom_range(1, 255));
		return u;
	endfunction

	// mostly keyword lines; small digit values make repeats and zero ids common
	function automatic void put_line();
		int          form;
		int          digits;
		int          digit_max;
		logic [15:0] pad;
		form = $urandom_range(0, 9);
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 3))
				0: pad = UNIT_TAB;
				1: pad = UNIT_SP;
				2: pad = UNIT_CR;
				default: pad = UNIT_LF;
			endcase
			put_unit(pad);
		end
		if (form < 7) begin
			put_unit(UNIT_P);
			put_unit(UNIT_V);
			put_unit(UNIT_US);
			digit_max = 9;
			case ($urandom_range(0, 9))
				0: digits = 0;
				7, 8: digits = $urandom_range(3, 6);
				9: digits = $urandom_range(10, 12);  // wraps past 2^32
				default: begin
					digits    = $urandom_range(1, 2);
					digit_max = 2;
				end
			endcase
			repeat (digits)
				put_unit(UNIT_D0 + 16'($urandom_range(0, digit_max)));
		end else if (form == 7) begin
			put_unit(UNIT_P);
			put_unit(noise_unit());
		end else if (form == 8) begin
			put_unit(UNIT_P);
			put_unit(UNIT_V);
			put_unit(noise_unit());
		end else begin
			repeat ($urandom_range(1, 4))
				put_unit(noise_unit());
		end
		case ($urandom_range(0, 4))
			0, 1: put_unit(UNIT_LF);
			2: put_unit(UNIT_CR);
			3: begin
				put_unit(noise_unit());
				put_unit(UNIT_LF);
			end
			default: ;  // line runs on into the next one
		endcase
	endfunction

	// one buffer: byte mode, BOM-led UTF-16, or lone FF lead; pops sprinkled in
	function automatic void queue_buffer(int pop_pct);
		int   shape;
		logic open_flag;
		logic close_flag;
		text_bytes.delete();
		shape     = $urandom_range(0, 9);
		wide_text = (shape < 3);
		if (wide_text) begin
			text_bytes.insert(text_bytes.size(), BOM_LO);
			text_bytes.insert(text_bytes.size(), BOM_HI);
		end else if (shape == 3) begin
			text_bytes.insert(text_bytes.size(), BOM_LO);
		end
		repeat ($urandom_range(1, 4))
			put_line();
		if (wide_text && $urandom_range(0, 3) == 0)
			text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
		// missing first/last marks exercise run-on and mid-run restarts
		open_flag  = ($urandom_range(0, 9) != 0);
		close_flag = ($urandom_range(0, 9) != 0);
		foreach (text_bytes[i]) begin
			if ($urandom_range(0, 99) < pop_pct)
				queue_pop();
			queue_text(text_bytes[i], open_flag && i == 0,
				close_flag && i == text_bytes.size() - 1);
		end
	endfunction

	// ------------------------------------------------------------------
	// Input side: offer queued transactions, predict each one accepted
	// ------------------------------------------------------------------
	task automatic drive_items();
		stim_t cur;
		logic  fire;
		cur = '0;
		while (stim_q.size() != 0 || in_valid) begin
			@(posedge clk);
			fire = in_valid && !in_stall;
			if (fire)
				predict_item(cur);
			if (!in_valid || fire) begin
				if (stim_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur = stim_q.pop_front();
					in_valid <= 1'b1;
					in_data  <= cur.item;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	endtask

	function automatic void record_fault(string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("ERROR: %s", msg);
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stall, one long hold on request, result checks
	// ------------------------------------------------------------------
	int   hold_left  = 0;
	logic hold_taken = 1'b0;

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expect_q.size() == 0) begin
					record_fault($sformatf("pop result id %h with no pop outstanding",
						out_data.popped_id));
				end else begin
					want = expect_q.pop_front();
					if (out_data.popped_id !== want.popped_id
						|| out_data.was_empty !== want.was_empty
						|| out_data.push_dropped !== want.push_dropped)
						record_fault($sformatf(
							"pop result id %h empty %b dropped %b, want id %h empty %b dropped %b",
							out_data.popped_id, out_data.was_empty, out_data.push_dropped,
							want.popped_id, want.was_empty, want.push_dropped));
				end
			end
			if (hold_request && !hold_taken) begin
				hold_left  = LONG_HOLD;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	// watchdog: a run with no transaction on either side for too long is hung
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("line_keyword_id_extract_stack_top verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		stim_t s;
		start_buffer();
		stack_fill = 0;
		lost_push  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// opening script, sender mostly active and receiver busy
		foreach (opening_script[i]) begin
			s                    = '0;
			s.item.cmd           = opening_script[i].cmd;
			s.item.data_byte     = opening_script[i].data_byte;
			s.item.first_byte    = opening_script[i].first_byte;
			s.item.last_byte     = opening_script[i].last_byte;
			s.fixed              = opening_script[i].fixed;
			s.want.popped_id     = opening_script[i].popped_id;
			s.want.was_empty     = opening_script[i].was_empty;
			s.want.push_dropped  = 1'b0;
			stim_q.insert(stim_q.size(), s);
		end
		drive_items();

		// random buffers, receiver mostly stalled
		while (stim_q.size() < 140)
			queue_buffer(10);
		drive_items();

		// random buffers, sender mostly idle
		tx_idle_pct = 85;
		rx_idle_pct <= 28;
		while (stim_q.size() < 140)
			queue_buffer(10);
		drive_items();

		// full rate; receiver holds off while pop-heavy traffic backs up
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		hold_request <= 1'b1;
		while (stim_q.size() < 40)
			queue_buffer(35);

		// short one-id buffers overflow the stack, then pop it dry
		repeat (STORE_DEPTH + 8) begin
			queue_text(8'(UNIT_P), 1'b1, 1'b0);
			queue_text(8'(UNIT_V), 1'b0, 1'b0);
			queue_text(8'(UNIT_US), 1'b0, 1'b0);
			queue_text(8'(UNIT_D0) + 8'($urandom_range(1, 9)), 1'b0, 1'b1);
		end
		repeat (STORE_DEPTH + 8)
			queue_pop();
		drive_items();

		while (expect_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);  // let any stray result show up

		if (fault_count == 0)
			$display("line_keyword_id_extract_stack_top verification clean");
		else
			$display("line_keyword_id_extract_stack_top verification failed");
		$finish;
	end

endmodule
